### sv/wwr_pkg.sv
// Shared types and codes for the whole-word replace stream unit.
// Holds the command encoding passed from the front end to the back end.
// No dependencies.
`default_nettype none

package wwr_pkg;

    // Input mode selector codes (s_tuser)
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_SRCH  = 2'd1;
    localparam logic [1:0] MODE_REPL  = 2'd2;
    localparam logic [1:0] MODE_TEXT  = 2'd3;

    // Word separator in sentence mode
    localparam logic [7:0] SPACE_CHAR = 8'd32;

    // Command queue depth between front and back
    localparam int Q_DEPTH = 2;

    typedef logic [2:0] op_t;

    // Classified commands
    localparam op_t OP_CLEAR     = 3'd0;
    localparam op_t OP_LOAD_SRCH = 3'd1;
    localparam op_t OP_LOAD_REPL = 3'd2;
    localparam op_t OP_CHAR      = 3'd3;
    localparam op_t OP_SPACE     = 3'd4;
    localparam op_t OP_EOT       = 3'd5;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
    } cmd_t;

endpackage

`default_nettype wire

### sv/whole_word_replace_stream_unit.sv
// Top level of the whole-word find and replace stream unit.
// Depends on wwr_pkg, wwr_front, wwr_queue, wwr_back (and wwr_ram below it).
//
//  channel | dir | tdata          | tlast         | tuser
//  --------+-----+----------------+---------------+------------------
//  s_*     | in  | [7:0] char_in  | end_of_text   | [1:0] mode
//  m_*     | out | [7:0] char_out | last_of_run   | [0] sentence_done
//
// Load and clear items are handled at dispatch; a passthrough or buffered text
// character also steps through an output load, or a search-word RAM read then compare.
// A word end steps through dispatch, a RAM read and an output load per character,
// then the space if there is one. A two-entry command queue lets the front keep
// accepting while the back emits; the output register absorbs a stall on m_tready.
// Reset is asynchronous, active low; the word stores need no clearing pass.
`default_nettype none

module whole_word_replace_stream_unit
    import wwr_pkg::*;
#(
    parameter int MAX_WORD = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_in
    input  wire logic       s_tlast,   // end_of_text
    input  wire logic [1:0] s_tuser,   // [1:0] mode
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] char_out
    output logic            m_tlast,   // last_of_run
    output logic [0:0]      m_tuser    // [0] sentence_done
);

    logic f_valid, f_ready;
    cmd_t f_cmd;
    logic q_valid, q_pop;
    cmd_t q_cmd;

    // Accept and classify
    wwr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    // Decouple front from back
    wwr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_cmd   (q_cmd)
    );

    // Execute and emit
    wwr_back #(.MAX_WORD(MAX_WORD)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### sv/wwr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the search word, replacement word and word buffer. No dependencies.
`default_nettype none

module wwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/wwr_front.sv
// Front end: accepts input items and classifies them into commands.
// Depends on wwr_pkg.
`default_nettype none

module wwr_front
    import wwr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_in
    input  wire logic       s_tlast,   // end_of_text
    input  wire logic [1:0] s_tuser,   // [1:0] mode
    output logic            cmd_valid,
    input  wire logic       cmd_ready,
    output cmd_t            cmd
);

    logic vld_reg, vld_next;
    cmd_t cmd_reg, cmd_next;
    op_t  op_dec;

    // Classify the incoming item
    always_comb
    begin
        case (s_tuser)
            MODE_CLEAR: op_dec = OP_CLEAR;
            MODE_SRCH:  op_dec = OP_LOAD_SRCH;
            MODE_REPL:  op_dec = OP_LOAD_REPL;
            MODE_TEXT:
            begin
                if (s_tlast)
                    op_dec = OP_EOT;
                else if (s_tdata == SPACE_CHAR)
                    op_dec = OP_SPACE;
                else
                    op_dec = OP_CHAR;
            end
            default:    op_dec = OP_CLEAR;
        endcase
    end

    assign s_tready  = !vld_reg || cmd_ready;
    assign cmd_valid = vld_reg;
    assign cmd       = cmd_reg;

    // Hold the classified command until the queue takes it
    always_comb
    begin
        vld_next = vld_reg;
        cmd_next = cmd_reg;
        if (cmd_ready)
            vld_next = 1'b0;
        if (s_tvalid && s_tready)
        begin
            vld_next    = 1'b1;
            cmd_next.op = op_dec;
            cmd_next.ch = s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

### sv/wwr_queue.sv
// Short command queue decoupling the front end from the back end.
// Depends on wwr_pkg.
`default_nettype none

module wwr_queue
    import wwr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cmd_t in_cmd,
    output logic      out_valid,
    input  wire logic out_pop,
    output cmd_t      out_cmd
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    cmd_t            entry [Q_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign in_ready  = (count_reg != CW'(Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed command
    always_ff @(posedge clk)
    begin
        if (push)
            entry[wr_ptr_reg] <= in_cmd;
    end

endmodule

`default_nettype wire

### sv/wwr_back.sv
// Back end: executes commands, owns the word stores and the output register.
// Depends on wwr_pkg and wwr_ram.
`default_nettype none

module wwr_back
    import wwr_pkg::*;
#(
    parameter int MAX_WORD = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire cmd_t       q_cmd,
    output logic            q_pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] char_out
    output logic            m_tlast,   // last_of_run
    output logic [0:0]      m_tuser    // [0] sentence_done
);

    localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int LW = $clog2(MAX_WORD + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMP  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd3;
    localparam logic [2:0] ST_TAIL = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [LW-1:0] search_len_reg, search_len_next;
    logic [LW-1:0] repl_len_reg, repl_len_next;
    logic [LW-1:0] word_len_reg, word_len_next;
    logic          still_match_reg, still_match_next;
    logic          passthru_reg, passthru_next;
    logic [7:0]    char_reg, char_next;
    logic          src_repl_reg, src_repl_next;
    logic [LW-1:0] burst_len_reg, burst_len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic          tail_vld_reg, tail_vld_next;
    logic          eot_reg, eot_next;
    logic          out_vld_reg, out_vld_next;
    logic [7:0]    out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;
    logic          out_done_reg, out_done_next;

    logic          srch_we, repl_we, word_we;
    logic          srch_re, burst_re;
    logic [7:0]    srch_rdata, repl_rdata, word_rdata, burst_data;
    logic          out_free, last_elem, is_match;
    logic [LW-1:0] flush_len;

    // Word stores
    wwr_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_srch_ram (
        .clk   (clk),
        .we    (srch_we),
        .waddr (search_len_reg[AW-1:0]),
        .wdata (q_cmd.ch),
        .re    (srch_re),
        .raddr (word_len_reg[AW-1:0]),
        .rdata (srch_rdata)
    );

    wwr_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_repl_ram (
        .clk   (clk),
        .we    (repl_we),
        .waddr (repl_len_reg[AW-1:0]),
        .wdata (q_cmd.ch),
        .re    (burst_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (repl_rdata)
    );

    wwr_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_word_ram (
        .clk   (clk),
        .we    (word_we),
        .waddr (word_len_reg[AW-1:0]),
        .wdata (q_cmd.ch),
        .re    (burst_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (word_rdata)
    );

    assign out_free   = !out_vld_reg || m_tready;
    assign burst_data = src_repl_reg ? repl_rdata : word_rdata;
    assign last_elem  = ((idx_reg + LW'(1)) == burst_len_reg);
    assign is_match   = still_match_reg && (search_len_reg != '0) &&
                        (word_len_reg == search_len_reg);
    assign flush_len  = passthru_reg ? '0 : (is_match ? repl_len_reg : word_len_reg);

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

    // Command sequencer
    always_comb
    begin
        state_next       = state_reg;
        search_len_next  = search_len_reg;
        repl_len_next    = repl_len_reg;
        word_len_next    = word_len_reg;
        still_match_next = still_match_reg;
        passthru_next    = passthru_reg;
        char_next        = char_reg;
        src_repl_next    = src_repl_reg;
        burst_len_next   = burst_len_reg;
        idx_next         = idx_reg;
        tail_vld_next    = tail_vld_reg;
        eot_next         = eot_reg;
        out_vld_next     = out_vld_reg;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;
        out_done_next    = out_done_reg;
        q_pop            = 1'b0;
        srch_we          = 1'b0;
        repl_we          = 1'b0;
        word_we          = 1'b0;
        srch_re          = 1'b0;
        burst_re         = 1'b0;

        // Drop the output item once taken
        if (m_tready)
            out_vld_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.op)
                        OP_CLEAR:
                        begin
                            search_len_next = '0;
                            repl_len_next   = '0;
                        end
                        OP_LOAD_SRCH:
                        begin
                            if (search_len_reg < LW'(MAX_WORD))
                            begin
                                srch_we         = 1'b1;
                                search_len_next = search_len_reg + LW'(1);
                            end
                        end
                        OP_LOAD_REPL:
                        begin
                            if (repl_len_reg < LW'(MAX_WORD))
                            begin
                                repl_we       = 1'b1;
                                repl_len_next = repl_len_reg + LW'(1);
                            end
                        end
                        OP_CHAR:
                        begin
                            char_next = q_cmd.ch;
                            if (passthru_reg)
                            begin
                                // Pass the character straight through
                                eot_next   = 1'b0;
                                state_next = ST_TAIL;
                            end
                            else if (word_len_reg >= LW'(MAX_WORD))
                            begin
                                // Buffer full: flush it, then the character
                                src_repl_next    = 1'b0;
                                burst_len_next   = LW'(MAX_WORD);
                                idx_next         = '0;
                                tail_vld_next    = 1'b1;
                                eot_next         = 1'b0;
                                passthru_next    = 1'b1;
                                still_match_next = 1'b0;
                                state_next       = ST_RD;
                            end
                            else
                            begin
                                // Buffer it and fetch the search char to compare
                                word_we    = 1'b1;
                                srch_re    = 1'b1;
                                state_next = ST_CMP;
                            end
                        end
                        OP_SPACE, OP_EOT:
                        begin
                            src_repl_next    = is_match;
                            burst_len_next   = flush_len;
                            idx_next         = '0;
                            tail_vld_next    = (q_cmd.op == OP_SPACE);
                            eot_next         = (q_cmd.op == OP_EOT);
                            char_next        = SPACE_CHAR;
                            word_len_next    = '0;
                            still_match_next = 1'b1;
                            passthru_next    = 1'b0;
                            if (flush_len != '0)
                                state_next = ST_RD;
                            else if (q_cmd.op == OP_SPACE)
                                state_next = ST_TAIL;
                            else
                                state_next = ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CMP:
            begin
                if (!((word_len_reg < search_len_reg) && (srch_rdata == char_reg)))
                    still_match_next = 1'b0;
                word_len_next = word_len_reg + LW'(1);
                state_next    = ST_IDLE;
            end
            ST_RD:
            begin
                burst_re   = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = burst_data;
                    out_last_next = last_elem && !tail_vld_reg;
                    out_done_next = last_elem && eot_reg;
                    idx_next      = idx_reg + LW'(1);
                    if (!last_elem)
                        state_next = ST_RD;
                    else if (tail_vld_reg)
                        state_next = ST_TAIL;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_TAIL:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = char_reg;
                    out_last_next = 1'b1;
                    out_done_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            search_len_reg  <= '0;
            repl_len_reg    <= '0;
            word_len_reg    <= '0;
            still_match_reg <= 1'b1;
            passthru_reg    <= 1'b0;
            burst_len_reg   <= '0;
            idx_reg         <= '0;
            tail_vld_reg    <= 1'b0;
            eot_reg         <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            search_len_reg  <= search_len_next;
            repl_len_reg    <= repl_len_next;
            word_len_reg    <= word_len_next;
            still_match_reg <= still_match_next;
            passthru_reg    <= passthru_next;
            burst_len_reg   <= burst_len_next;
            idx_reg         <= idx_next;
            tail_vld_reg    <= tail_vld_next;
            eot_reg         <= eot_next;
            out_vld_reg     <= out_vld_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        src_repl_reg <= src_repl_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

`ifndef SYNTHESIS
    a_word_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        word_len_reg <= LW'(MAX_WORD))
        else $error("word length past buffer size");

    a_burst_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD || state_reg == ST_WR) |->
            (burst_len_reg != '0 && idx_reg < burst_len_reg))
        else $error("burst index out of range");

    a_passthru_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        passthru_reg |-> !still_match_reg)
        else $error("passthrough word still marked as matching");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_done_reg) |-> out_last_reg)
        else $error("sentence done without end of run");

    a_cmp_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> ($past(state_reg) == ST_IDLE && state_next == ST_IDLE))
        else $error("compare step not a single cycle after dispatch");
`endif

endmodule

`default_nettype wire
